>>> hw/rtl/si32alu_pkg.sv
// ----------------------------------------------------------------------------
// si32alu_pkg
// shared types and constants of the 32-bit signed integer alu
// ----------------------------------------------------------------------------
package si32alu_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned DivSteps  = DataWidth;

   typedef enum logic [4:0] {
      CMD_ADD   = 5'd0,
      CMD_SUB   = 5'd1,
      CMD_MUL   = 5'd2,
      CMD_DIV   = 5'd3,
      CMD_MOD   = 5'd4,
      CMD_XOR   = 5'd5,
      CMD_AND   = 5'd6,
      CMD_OR    = 5'd7,
      CMD_SHL   = 5'd8,
      CMD_SHR   = 5'd9,
      CMD_EQ    = 5'd10,
      CMD_NE    = 5'd11,
      CMD_LT    = 5'd12,
      CMD_LE    = 5'd13,
      CMD_GT    = 5'd14,
      CMD_GE    = 5'd15,
      CMD_PLUS  = 5'd16,
      CMD_NEG   = 5'd17,
      CMD_COMPL = 5'd18,
      CMD_NOT   = 5'd19
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_QUO   = 2'd1,
      KIND_REM   = 2'd2
   } kind_type;

   localparam logic CsrTrueWord  = 1'b0;
   localparam logic CsrFalseWord = 1'b1;

   typedef struct packed {
      logic                   valid;
      kind_type               kind;
      logic                   neg;
      logic                   err;
      logic [DataWidth-1:0]   res;
      logic [DataWidth-1:0]   rem;
      logic [DataWidth-1:0]   quo;
      logic [DataWidth-1:0]   dvs;
   } stage_type;

endpackage

>>> hw/rtl/si32alu_front.sv
// ----------------------------------------------------------------------------
// si32alu_front
// decode stage: simple operations, compares, divider operand setup
// ----------------------------------------------------------------------------
module si32alu_front
   import si32alu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [4:0]           cmd,
   input  logic [DataWidth-1:0] left_operand,
   input  logic [DataWidth-1:0] right_operand,
   input  logic [DataWidth-1:0] true_word,
   input  logic [DataWidth-1:0] false_word,
   output stage_type            out_stage
);

   stage_type stage_ff, stage_in;
   logic [DataWidth-1:0] a, b, am, bm;
   logic sa_lt, eq, bad_shift, aneg, bneg;

   always_comb begin
      a         = left_operand;
      b         = right_operand;
      aneg      = a[DataWidth-1];
      bneg      = b[DataWidth-1];
      am        = aneg ? (~a + 1'b1) : a;
      bm        = bneg ? (~b + 1'b1) : b;
      sa_lt     = $signed(a) < $signed(b);
      eq        = a == b;
      bad_shift = |b[DataWidth-1:5];
      stage_in       = '0;
      stage_in.valid = in_valid;
      stage_in.kind  = KIND_PLAIN;
      stage_in.quo   = am;
      stage_in.dvs   = bm;
      case (cmd_type'(cmd))
         CMD_ADD:   stage_in.res = a + b;
         CMD_SUB:   stage_in.res = a - b;
         CMD_MUL:   stage_in.res = a * b;
         CMD_DIV, CMD_MOD: begin
            if (b == '0) begin
               stage_in.err = 1'b1;
            end else if (cmd_type'(cmd) == CMD_DIV) begin
               stage_in.kind = KIND_QUO;
               stage_in.neg  = aneg ^ bneg;
            end else begin
               stage_in.kind = KIND_REM;
               stage_in.neg  = aneg;
            end
         end
         CMD_XOR:   stage_in.res = a ^ b;
         CMD_AND:   stage_in.res = a & b;
         CMD_OR:    stage_in.res = a | b;
         CMD_SHL: begin
            if (bad_shift) stage_in.err = 1'b1;
            else stage_in.res = a << b[4:0];
         end
         CMD_SHR: begin
            if (bad_shift) stage_in.err = 1'b1;
            else stage_in.res = $unsigned($signed(a) >>> b[4:0]);
         end
         CMD_EQ:    stage_in.res = eq ? true_word : false_word;
         CMD_NE:    stage_in.res = !eq ? true_word : false_word;
         CMD_LT:    stage_in.res = sa_lt ? true_word : false_word;
         CMD_LE:    stage_in.res = (sa_lt || eq) ? true_word : false_word;
         CMD_GT:    stage_in.res = !(sa_lt || eq) ? true_word : false_word;
         CMD_GE:    stage_in.res = !sa_lt ? true_word : false_word;
         CMD_PLUS:  stage_in.res = a;
         CMD_NEG:   stage_in.res = ~a + 1'b1;
         CMD_COMPL: stage_in.res = ~a;
         CMD_NOT:   stage_in.res = (a == false_word) ? true_word : false_word;
         default:   stage_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

>>> hw/rtl/si32alu_div_stage.sv
// ----------------------------------------------------------------------------
// si32alu_div_stage
// one restoring division step, one quotient bit per stage
// ----------------------------------------------------------------------------
module si32alu_div_stage
   import si32alu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  stage_type in_stage,
   output stage_type out_stage
);

   stage_type stage_ff, stage_in;
   logic [DataWidth:0] trial, diff;

   always_comb begin
      trial    = {in_stage.rem, in_stage.quo[DataWidth-1]};
      diff     = trial - {1'b0, in_stage.dvs};
      stage_in = in_stage;
      if (!diff[DataWidth]) begin
         stage_in.rem = diff[DataWidth-1:0];
         stage_in.quo = {in_stage.quo[DataWidth-2:0], 1'b1};
      end else begin
         stage_in.rem = trial[DataWidth-1:0];
         stage_in.quo = {in_stage.quo[DataWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

>>> hw/rtl/signed_int32_alu.sv
// ----------------------------------------------------------------------------
// signed_int32_alu
// 32-bit signed integer alu with c operator semantics, fully pipelined
// ----------------------------------------------------------------------------
// One request enters per cycle while the output register is empty or being
// taken, when the whole pipe advances; a stalled response holds the pipe. Each
// request gives one response through a decode stage, 32 restoring divider
// stages (one quotient bit each, one 33-bit subtract per stage) and a sign-fix
// output register. Every operation flows through the same pipe so responses
// keep request order. Division or remainder by zero and shift counts outside
// 0..31 return 0 with the error bit set. The user must write true_word and
// false_word through the csr port while no request is in flight; not enforced.
module signed_int32_alu
   import si32alu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: [4:0] cmd, [36:5] left_operand, [68:37] right_operand
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // response: [31:0] result_value, [32] error_flag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // csr write: index 0 true_word, index 1 false_word
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [DataWidth-1:0] true_word_ff, false_word_ff;
   logic                 en;
   stage_type            pipe [DivSteps+1];
   logic                 rsp_valid_ff;
   logic [DataWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_err_ff;

   // whole pipe moves when output slot is free or draining
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         true_word_ff  <= 32'd1;
         false_word_ff <= 32'd0;
      end else if (csr_valid) begin
         if (csr_index == CsrTrueWord) true_word_ff <= csr_data;
         else false_word_ff <= csr_data;
      end
   end

   si32alu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_tvalid),
      .cmd           (req_tdata[4:0]),
      .left_operand  (req_tdata[36:5]),
      .right_operand (req_tdata[68:37]),
      .true_word     (true_word_ff),
      .false_word    (false_word_ff),
      .out_stage     (pipe[0])
   );

   // divider steps, msb of the quotient first
   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      si32alu_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_stage  (pipe[i]),
         .out_stage (pipe[i+1])
      );
   end

   // sign fix of quotient or remainder; other results pass through
   always_comb begin
      case (pipe[DivSteps].kind)
         KIND_QUO: rsp_value_in = pipe[DivSteps].neg ?
                                  (~pipe[DivSteps].quo + 1'b1) : pipe[DivSteps].quo;
         KIND_REM: rsp_value_in = pipe[DivSteps].neg ?
                                  (~pipe[DivSteps].rem + 1'b1) : pipe[DivSteps].rem;
         default:  rsp_value_in = pipe[DivSteps].res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= pipe[DivSteps].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= rsp_value_in;
         rsp_err_ff   <= pipe[DivSteps].err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_err_ff, rsp_value_ff};

`ifndef SYNTHESIS
   // stalled pipe keeps its first stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(pipe[0].valid))
      else $error("pipe moved during stall");
   // an error response carries zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("error response with nonzero value");
   // request accepted in a cycle reaches decode stage
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> pipe[0].valid)
      else $error("accepted request lost");
`endif

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the 32-bit signed integer alu
// ----------------------------------------------------------------------------
// A directed table covers operand extremes, every command and the error,
// wrap and unused-code cases. A random stream of about 1400 requests follows.
// Each accepted request is run through a local alu predictor and queued, and
// each response is compared with the oldest queued result. The true and false
// words are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import si32alu_pkg::*;
();

   localparam int PipeDepth = 34;
   localparam int IdleLimit = 20000;

   typedef struct {
      logic [4:0]  cmd;
      logic [31:0] lhs;
      logic [31:0] rhs;
      logic        typed;     // expected value given in the table
      logic [31:0] want_val;
      logic        want_err;
   } alu_row_type;

   typedef struct {
      logic [31:0] val;
      logic        err;
   } alu_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   // local copies of the csr words
   logic [31:0] true_word;
   logic [31:0] false_word;

   alu_answer_type pending_answers[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          stim_done = 1'b0;
   bit          hold_off = 1'b0;   // receiver long stall request

   signed_int32_alu dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic alu_answer_type alu_predict(logic [4:0] cmd, logic [31:0] a,
                                                  logic [31:0] b);
      alu_answer_type ans;
      logic signed [31:0] sa;
      logic signed [31:0] sb;
      logic [31:0] am;
      logic [31:0] bm;
      logic [31:0] q;
      ans.val = '0;
      ans.err = 1'b0;
      sa = a;
      sb = b;
      am = a[31] ? -a : a;
      bm = b[31] ? -b : b;
      case (cmd)
         CMD_ADD:   ans.val = a + b;
         CMD_SUB:   ans.val = a - b;
         CMD_MUL:   ans.val = a * b;
         CMD_DIV, CMD_MOD: begin
            if (b == 0) ans.err = 1'b1;
            else if (cmd == CMD_DIV) begin
               q = am / bm;
               ans.val = (a[31] != b[31]) ? -q : q;
            end else begin
               q = am % bm;
               ans.val = a[31] ? -q : q;
            end
         end
         CMD_XOR:   ans.val = a ^ b;
         CMD_AND:   ans.val = a & b;
         CMD_OR:    ans.val = a | b;
         CMD_SHL, CMD_SHR: begin
            if (b > 31) ans.err = 1'b1;
            else if (cmd == CMD_SHL) ans.val = a << b[4:0];
            else ans.val = sa >>> b[4:0];
         end
         CMD_EQ:    ans.val = (sa == sb) ? true_word : false_word;
         CMD_NE:    ans.val = (sa != sb) ? true_word : false_word;
         CMD_LT:    ans.val = (sa <  sb) ? true_word : false_word;
         CMD_LE:    ans.val = (sa <= sb) ? true_word : false_word;
         CMD_GT:    ans.val = (sa >  sb) ? true_word : false_word;
         CMD_GE:    ans.val = (sa >= sb) ? true_word : false_word;
         CMD_PLUS:  ans.val = a;
         CMD_NEG:   ans.val = -a;
         CMD_COMPL: ans.val = ~a;
         CMD_NOT:   ans.val = (a == false_word) ? true_word : false_word;
         default:   ans.val = '0;   // unused codes
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   function automatic int short_or_long_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // drive one request and wait for acceptance; valid stays high across
   // back-to-back requests so it is never dropped and raised in one step
   task automatic send_request(logic [4:0] cmd, logic [31:0] a, logic [31:0] b,
                               bit burst);
      int gap;
      gap = burst ? 0 : short_or_long_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {3'b000, b, a, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(alu_predict(cmd, a, b));
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   // write a csr with the pipe empty
   task automatic write_csr(logic idx, logic [31:0] data);
      req_tvalid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (PipeDepth + 4) @(negedge clock);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CsrTrueWord) true_word = data;
      else false_word = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 8)) - 4);
         3: return $urandom_range(0, 40);
         4: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [4:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      for (int n = 0; n < count; n++) begin
         cmd = ($urandom_range(0, 15) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 19));
         a = random_operand();
         b = random_operand();
         // shift counts mostly in range, comparisons often equal operands
         if ((cmd == CMD_SHL || cmd == CMD_SHR) && $urandom_range(0, 3) != 0)
            b = $urandom_range(0, 31);
         if (cmd >= CMD_EQ && cmd <= CMD_GE && $urandom_range(0, 3) == 0) b = a;
         if (cmd == CMD_NOT && $urandom_range(0, 2) == 0) a = false_word;
         send_request(cmd, a, b, 1'b0);
      end
      end_burst();
   endtask

   // directed table: expected value typed where obvious
   alu_row_type directed_rows[] = '{
      '{CMD_ADD,  32'h7fff_ffff, 32'h1,          1, 32'h8000_0000, 0},
      '{CMD_SUB,  32'h8000_0000, 32'h1,          1, 32'h7fff_ffff, 0},
      '{CMD_MUL,  32'h8000_0000, 32'hffff_ffff,  1, 32'h8000_0000, 0},
      '{CMD_DIV,  32'h8000_0000, 32'hffff_ffff,  1, 32'h8000_0000, 0},
      '{CMD_MOD,  32'h8000_0000, 32'hffff_ffff,  1, 32'h0,         0},
      '{CMD_DIV,  32'h1234,      32'h0,          1, 32'h0,         1},
      '{CMD_MOD,  32'h8000_0000, 32'h0,          1, 32'h0,         1},
      '{CMD_DIV,  32'hffff_fff9, 32'h2,          0, 32'h0,         0},
      '{CMD_MOD,  32'hffff_fff9, 32'h2,          0, 32'h0,         0},
      '{CMD_XOR,  32'hffff_ffff, 32'h5555_5555,  0, 32'h0,         0},
      '{CMD_AND,  32'hffff_ffff, 32'h0,          1, 32'h0,         0},
      '{CMD_OR,   32'h0,         32'hffff_ffff,  1, 32'hffff_ffff, 0},
      '{CMD_SHL,  32'hffff_ffff, 32'd31,         1, 32'h8000_0000, 0},
      '{CMD_SHL,  32'h1,         32'd32,         1, 32'h0,         1},
      '{CMD_SHR,  32'h8000_0000, 32'd31,         1, 32'hffff_ffff, 0},
      '{CMD_SHR,  32'h8000_0000, 32'hffff_ffff,  1, 32'h0,         1},
      '{CMD_SHR,  32'h8000_0000, 32'd0,          1, 32'h8000_0000, 0},
      '{CMD_EQ,   32'h8000_0000, 32'h8000_0000,  1, 32'h1,         0},
      '{CMD_NE,   32'h7fff_ffff, 32'h8000_0000,  0, 32'h0,         0},
      '{CMD_LT,   32'h8000_0000, 32'h7fff_ffff,  1, 32'h1,         0},
      '{CMD_LE,   32'h7fff_ffff, 32'h7fff_ffff,  0, 32'h0,         0},
      '{CMD_GT,   32'h8000_0000, 32'h7fff_ffff,  1, 32'h0,         0},
      '{CMD_GE,   32'hffff_ffff, 32'h0,          0, 32'h0,         0},
      '{CMD_PLUS, 32'h8000_0000, 32'h1,          1, 32'h8000_0000, 0},
      '{CMD_NEG,  32'h8000_0000, 32'h0,          1, 32'h8000_0000, 0},
      '{CMD_COMPL,32'h0,         32'h0,          1, 32'hffff_ffff, 0},
      '{CMD_NOT,  32'h0,         32'h0,          1, 32'h1,         0},
      '{5'd31,    32'hffff_ffff, 32'hffff_ffff,  1, 32'h0,         0}
   };

   initial begin : stimulus
      alu_answer_type ans;
      true_word  = 32'h1;
      false_word = 32'h0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, typed values checked against the predictor too
      foreach (directed_rows[i]) begin
         ans = alu_predict(directed_rows[i].cmd, directed_rows[i].lhs,
                           directed_rows[i].rhs);
         if (directed_rows[i].typed && ans.val !== directed_rows[i].want_val) begin
            $error("table row %0d: result_value expected %h actual %h", i,
                   directed_rows[i].want_val, ans.val);
            error_count++;
         end
         if (directed_rows[i].typed && ans.err !== directed_rows[i].want_err) begin
            $error("table row %0d: error_flag expected %b actual %b", i,
                   directed_rows[i].want_err, ans.err);
            error_count++;
         end
         send_request(directed_rows[i].cmd, directed_rows[i].lhs,
                      directed_rows[i].rhs, 1'b1);
      end
      end_burst();

      random_phase(300);

      // receiver stalls for a long time while requests keep coming
      hold_off = 1'b1;
      for (int n = 0; n < 80; n++)
         send_request(5'($urandom_range(0, 19)), $urandom(), $urandom_range(0, 31), 1'b1);
      end_burst();

      // extreme and equal words
      write_csr(CsrTrueWord, 32'h8000_0000);
      write_csr(CsrFalseWord, 32'h7fff_ffff);
      random_phase(300);
      write_csr(CsrTrueWord, 32'h7fff_ffff);
      write_csr(CsrFalseWord, 32'h8000_0000);
      random_phase(250);
      write_csr(CsrTrueWord, 32'h5a5a_5a5a);
      write_csr(CsrFalseWord, 32'h5a5a_5a5a);
      random_phase(150);
      write_csr(CsrTrueWord, $urandom());
      write_csr(CsrFalseWord, $urandom());
      random_phase(300);
      stim_done = 1'b1;
   end

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin : receiver
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         gap = short_or_long_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // compare each response with the oldest predicted result
   always @(posedge clock) begin
      alu_answer_type exp_ans;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("response with no request pending: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_tdata[31:0] !== exp_ans.val) begin
               $error("result_value expected %h actual %h", exp_ans.val,
                      rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[32] !== exp_ans.err) begin
               $error("error_flag expected %b actual %b", exp_ans.err,
                      rsp_tdata[32]);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : finish_run
      fork
         begin
            wait (stim_done && pending_answers.size() == 0);
            repeat (PipeDepth + 10) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IdleLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      join_any
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/si32alu_pkg.sv
hw/rtl/si32alu_front.sv
hw/rtl/si32alu_div_stage.sv
hw/rtl/signed_int32_alu.sv
tb/tb_top.sv
